// File: sv/stcf_thread_scheduler_macros.svh
// Assertion shorthands used by the top-level scheduler file.
`ifndef STCF_THREAD_SCHEDULER_MACROS_SVH
`define STCF_THREAD_SCHEDULER_MACROS_SVH

// Check a consequence in the same cycle.
`define STCF_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the next cycle.
`define STCF_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/stcf_pkg.sv
package stcf_pkg;

  typedef enum logic [1:0] {K_CREATE, K_SCHED, K_JOIN, K_EXIT} kind_t;
  typedef enum logic [1:0] {STS_OK, STS_BLOCKED, STS_FULL, STS_UNKNOWN} status_t;
  typedef enum logic [1:0] {TS_RUN, TS_BLOCK, TS_DONE, TS_DESTROY} thread_st_t;

  typedef enum logic [2:0] {
    OP_NOP, OP_INSERT, OP_PURGE, OP_EXTRACT, OP_JOIN, OP_WAKE
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CMD, S_PURGE, S_PICK, S_REINS, S_DONE
  } sched_state_t;

  localparam int ID_BITS = 8;

  typedef struct packed {
    logic               valid;
    logic [ID_BITS-1:0] id;
    thread_st_t         st;
    logic               wait_valid;
    logic [ID_BITS-1:0] wait_id;
  } slot_meta_t;

  typedef struct packed {
    cell_op_t           op;
    slot_meta_t         new_meta;
    logic [ID_BITS-1:0] target;
    logic [ID_BITS-1:0] wake_id;
  } cell_ctl_t;

  typedef struct packed {
    logic full;
    logic any_destroy;
    logic any_run;
    logic join_done;
    logic join_live;
  } q_stat_t;

  typedef struct packed {
    kind_t              kind;
    logic [ID_BITS-1:0] target_id;
  } in_req_t;

  typedef struct packed {
    logic [ID_BITS-1:0] running_id;
    logic [ID_BITS-1:0] new_id;
    logic               switched;
    status_t            status;
  } out_res_t;

endpackage

// File: sv/stcf_cell.sv
module stcf_cell #(
  parameter int COUNT_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  stcf_pkg::cell_ctl_t     ctl,
  input  logic [COUNT_BITS-1:0]   new_cnt,
  input  logic                    head_i,
  input  stcf_pkg::slot_meta_t    left_meta,
  input  logic [COUNT_BITS-1:0]   left_cnt,
  input  logic                    shift_in,
  input  stcf_pkg::slot_meta_t    right_meta,
  input  logic [COUNT_BITS-1:0]   right_cnt,
  input  logic                    del_in,
  output stcf_pkg::slot_meta_t    meta_o,
  output logic [COUNT_BITS-1:0]   cnt_o,
  output logic                    shift_out,
  output logic                    del_out,
  output logic                    sel_o,
  output logic                    join_done_o,
  output logic                    join_live_o,
  output logic                    destroy_o,
  output logic                    run_o
);

  stcf_pkg::slot_meta_t  meta_r, meta_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  v, cmp, hit, id_match, wake;

  // Local flags for the chains
  assign v         = meta_r.valid;
  assign cmp       = head_i ? (cnt_r > new_cnt) : (cnt_r >= new_cnt);
  assign shift_out = v && (shift_in || cmp);
  assign destroy_o = v && (meta_r.st == stcf_pkg::TS_DESTROY);
  assign run_o     = v && (meta_r.st == stcf_pkg::TS_RUN);
  assign hit       = (ctl.op == stcf_pkg::OP_PURGE)   ? destroy_o :
                     (ctl.op == stcf_pkg::OP_EXTRACT) ? run_o : 1'b0;
  assign del_out   = del_in || hit;
  assign sel_o     = hit && !del_in;
  assign id_match  = v && (meta_r.id == ctl.target);
  assign join_done_o = id_match && (meta_r.st == stcf_pkg::TS_DONE);
  assign join_live_o = id_match && ((meta_r.st == stcf_pkg::TS_RUN) ||
                                    (meta_r.st == stcf_pkg::TS_BLOCK));
  assign wake = v && (meta_r.st == stcf_pkg::TS_BLOCK) && meta_r.wait_valid &&
                (meta_r.wait_id == ctl.wake_id);

  // Next slot contents
  always_comb begin
    meta_nxt = meta_r;
    cnt_nxt  = cnt_r;
    unique case (ctl.op)
      stcf_pkg::OP_INSERT: begin
        if (shift_in) begin
          meta_nxt = left_meta;
          cnt_nxt  = left_cnt;
        end else if ((shift_out || !v) && (head_i || left_meta.valid)) begin
          meta_nxt = ctl.new_meta;
          cnt_nxt  = new_cnt;
        end
      end
      stcf_pkg::OP_PURGE, stcf_pkg::OP_EXTRACT: begin
        if (del_out) begin
          meta_nxt = right_meta;
          cnt_nxt  = right_cnt;
        end
      end
      stcf_pkg::OP_JOIN: begin
        if (join_done_o) meta_nxt.st = stcf_pkg::TS_DESTROY;
      end
      stcf_pkg::OP_WAKE: begin
        if (wake) begin
          meta_nxt.st         = stcf_pkg::TS_RUN;
          meta_nxt.wait_valid = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r <= '0;
    end else begin
      meta_r <= meta_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
  end

  assign meta_o = meta_r;
  assign cnt_o  = cnt_r;

endmodule

// File: sv/stcf_queue.sv
module stcf_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  stcf_pkg::cell_ctl_t   ctl,
  input  logic [COUNT_BITS-1:0] new_cnt,
  output stcf_pkg::q_stat_t     stat,
  output stcf_pkg::slot_meta_t  sel_meta,
  output logic [COUNT_BITS-1:0] sel_cnt
);

  stcf_pkg::slot_meta_t  meta  [QUEUE_DEPTH];
  logic [COUNT_BITS-1:0] cnt   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] shift, del, sel, jdone, jlive, dstr, runb;

  // Row of slots, ordered head first
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    stcf_pkg::slot_meta_t  lm, rm;
    logic [COUNT_BITS-1:0] lc, rc;
    logic                  si, di;

    if (i == 0) begin : g_head
      assign lm = '0;
      assign lc = '0;
      assign si = 1'b0;
      assign di = 1'b0;
    end else begin : g_body
      assign lm = meta[i-1];
      assign lc = cnt[i-1];
      assign si = shift[i-1];
      assign di = del[i-1];
    end

    if (i == QUEUE_DEPTH-1) begin : g_tail
      assign rm = '0;
      assign rc = '0;
    end else begin : g_mid
      assign rm = meta[i+1];
      assign rc = cnt[i+1];
    end

    stcf_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_cnt    (new_cnt),
      .head_i     ((i == 0) ? 1'b1 : 1'b0),
      .left_meta  (lm),
      .left_cnt   (lc),
      .shift_in   (si),
      .right_meta (rm),
      .right_cnt  (rc),
      .del_in     (di),
      .meta_o     (meta[i]),
      .cnt_o      (cnt[i]),
      .shift_out  (shift[i]),
      .del_out    (del[i]),
      .sel_o      (sel[i]),
      .join_done_o(jdone[i]),
      .join_live_o(jlive[i]),
      .destroy_o  (dstr[i]),
      .run_o      (runb[i])
    );
  end

  // Gather status and the one selected slot
  always_comb begin
    sel_meta = '0;
    sel_cnt  = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      sel_meta = sel_meta | (sel[i] ? meta[i] : '0);
      sel_cnt  = sel_cnt  | (sel[i] ? cnt[i]  : '0);
    end
  end

  assign stat.full        = meta[QUEUE_DEPTH-1].valid;
  assign stat.any_destroy = |dstr;
  assign stat.any_run     = |runb;
  assign stat.join_done   = |jdone;
  assign stat.join_live   = |jlive;

endmodule

// File: sv/stcf_thread_scheduler.sv
// Channel  Ports                          Request
// in       in_valid/in_ready/in_data      kind, target_id
// out      out_valid/out_ready/out_data   running_id, new_id, switched, status
//
// Create, plain join and idle requests go from the command state to the result
// register. A schedule goes through purge, where the slot row closes one gap per
// cycle until no destroy entry is left, then pick, requeue and done; with nothing
// runnable it skips requeue. Join with block and exit take the same path.
// One request is in flight at a time; a new one is taken once the last result
// is in the output register. Reset is synchronous and clears all slot metadata at once.
`include "stcf_thread_scheduler_macros.svh"

module stcf_thread_scheduler #(
  parameter int QUEUE_DEPTH = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  stcf_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output stcf_pkg::out_res_t out_data
);

  localparam int NID_BITS = stcf_pkg::ID_BITS + 1;

  stcf_pkg::sched_state_t state_r, state_nxt;
  stcf_pkg::in_req_t      req_r, req_nxt;
  stcf_pkg::slot_meta_t   run_r, run_nxt, prev_r, prev_nxt;
  logic [COUNT_BITS-1:0]  run_cnt_r, run_cnt_nxt, prev_cnt_r, prev_cnt_nxt;
  logic                   run_valid_r, run_valid_nxt;
  logic [NID_BITS-1:0]    next_id_r, next_id_nxt, eff_next;
  logic [stcf_pkg::ID_BITS-1:0] new_id_r, new_id_nxt;
  logic                   sw_r, sw_nxt;
  stcf_pkg::status_t      sts_r, sts_nxt;
  logic                   out_valid_r, out_valid_nxt;
  stcf_pkg::out_res_t     out_data_r, out_data_nxt;

  stcf_pkg::cell_ctl_t    ctl;
  logic [COUNT_BITS-1:0]  ctl_cnt;
  stcf_pkg::q_stat_t      q_stat;
  stcf_pkg::slot_meta_t   sel_meta;
  logic [COUNT_BITS-1:0]  sel_cnt;
  logic                   first_create, create_full, out_free;

  stcf_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .COUNT_BITS(COUNT_BITS)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .new_cnt (ctl_cnt),
    .stat    (q_stat),
    .sel_meta(sel_meta),
    .sel_cnt (sel_cnt)
  );

  assign first_create = !run_valid_r && (next_id_r == '0);
  assign eff_next     = first_create ? NID_BITS'(1) : next_id_r;
  assign create_full  = q_stat.full || eff_next[NID_BITS-1];
  assign out_free     = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stcf_pkg::S_IDLE:  if (in_valid) state_nxt = stcf_pkg::S_CMD;
      stcf_pkg::S_CMD: begin
        unique case (req_r.kind)
          stcf_pkg::K_CREATE: state_nxt = stcf_pkg::S_DONE;
          stcf_pkg::K_JOIN:
            state_nxt = (run_valid_r && q_stat.join_live) ? stcf_pkg::S_PURGE
                                                          : stcf_pkg::S_DONE;
          default:
            state_nxt = run_valid_r ? stcf_pkg::S_PURGE : stcf_pkg::S_DONE;
        endcase
      end
      stcf_pkg::S_PURGE: if (!q_stat.any_destroy) state_nxt = stcf_pkg::S_PICK;
      stcf_pkg::S_PICK:
        state_nxt = q_stat.any_run ? stcf_pkg::S_REINS : stcf_pkg::S_DONE;
      stcf_pkg::S_REINS: state_nxt = stcf_pkg::S_DONE;
      stcf_pkg::S_DONE:  if (out_free) state_nxt = stcf_pkg::S_IDLE;
      default:           state_nxt = stcf_pkg::S_IDLE;
    endcase
  end

  // Datapath and slot row commands
  always_comb begin
    req_nxt       = req_r;
    run_nxt       = run_r;
    run_cnt_nxt   = run_cnt_r;
    run_valid_nxt = run_valid_r;
    prev_nxt      = prev_r;
    prev_cnt_nxt  = prev_cnt_r;
    next_id_nxt   = next_id_r;
    new_id_nxt    = new_id_r;
    sw_nxt        = sw_r;
    sts_nxt       = sts_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ctl           = '0;
    ctl.op        = stcf_pkg::OP_NOP;
    ctl.target    = req_r.target_id;
    ctl.wake_id   = run_r.id;
    ctl_cnt       = '0;
    in_ready      = (state_r == stcf_pkg::S_IDLE);

    unique case (state_r)
      stcf_pkg::S_IDLE: begin
        req_nxt    = in_data;
        new_id_nxt = '0;
        sw_nxt     = 1'b0;
        sts_nxt    = stcf_pkg::STS_OK;
      end
      stcf_pkg::S_CMD: begin
        unique case (req_r.kind)
          stcf_pkg::K_CREATE: begin
            if (first_create) begin
              run_nxt       = '0;
              run_nxt.valid = 1'b1;
              run_nxt.st    = stcf_pkg::TS_RUN;
              run_cnt_nxt   = '0;
              run_valid_nxt = 1'b1;
              next_id_nxt   = eff_next;
            end
            if (create_full) begin
              sts_nxt = stcf_pkg::STS_FULL;
            end else begin
              new_id_nxt            = eff_next[stcf_pkg::ID_BITS-1:0];
              next_id_nxt           = eff_next + NID_BITS'(1);
              ctl.op                = stcf_pkg::OP_INSERT;
              ctl.new_meta.valid    = 1'b1;
              ctl.new_meta.id       = eff_next[stcf_pkg::ID_BITS-1:0];
              ctl.new_meta.st       = stcf_pkg::TS_RUN;
            end
          end
          stcf_pkg::K_JOIN: begin
            if (!run_valid_r || !(q_stat.join_done || q_stat.join_live)) begin
              sts_nxt = stcf_pkg::STS_UNKNOWN;
            end else if (q_stat.join_done) begin
              ctl.op = stcf_pkg::OP_JOIN;
            end else begin
              run_nxt.st         = stcf_pkg::TS_BLOCK;
              run_nxt.wait_valid = 1'b1;
              run_nxt.wait_id    = req_r.target_id;
              sts_nxt            = stcf_pkg::STS_BLOCKED;
            end
          end
          stcf_pkg::K_EXIT: begin
            if (run_valid_r) begin
              run_nxt.st = stcf_pkg::TS_DONE;
              ctl.op     = stcf_pkg::OP_WAKE;
            end
          end
          default: begin
          end
        endcase
      end
      stcf_pkg::S_PURGE: begin
        if (q_stat.any_destroy) ctl.op = stcf_pkg::OP_PURGE;
      end
      stcf_pkg::S_PICK: begin
        if (q_stat.any_run) begin
          ctl.op       = stcf_pkg::OP_EXTRACT;
          prev_nxt     = run_r;
          prev_cnt_nxt = (run_cnt_r == '1) ? run_cnt_r : run_cnt_r + COUNT_BITS'(1);
          run_nxt      = sel_meta;
          run_cnt_nxt  = sel_cnt;
          sw_nxt       = 1'b1;
        end
      end
      stcf_pkg::S_REINS: begin
        if (!q_stat.full) begin
          ctl.op       = stcf_pkg::OP_INSERT;
          ctl.new_meta = prev_r;
          ctl_cnt      = prev_cnt_r;
        end
      end
      stcf_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.running_id = run_valid_r ? run_r.id : '0;
          out_data_nxt.new_id     = new_id_r;
          out_data_nxt.switched   = sw_r;
          out_data_nxt.status     = sts_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stcf_pkg::S_IDLE;
      run_valid_r <= 1'b0;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_valid_r <= run_valid_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    run_r      <= run_nxt;
    run_cnt_r  <= run_cnt_nxt;
    prev_r     <= prev_nxt;
    prev_cnt_r <= prev_cnt_nxt;
    new_id_r   <= new_id_nxt;
    sw_r       <= sw_nxt;
    sts_r      <= sts_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `STCF_AST_NEXT(a_accept_cmd, in_valid && in_ready, state_r == stcf_pkg::S_CMD, "request lost")
  `STCF_AST_NOW(a_reins_room, state_r == stcf_pkg::S_REINS, !q_stat.full, "no room to requeue")
  `STCF_AST_NEXT(a_pick_none, (state_r == stcf_pkg::S_PICK) && !q_stat.any_run, state_r == stcf_pkg::S_DONE, "bad pick")
  `STCF_AST_NOW(a_full_no_id, out_valid && (out_data.status == stcf_pkg::STS_FULL), out_data.new_id == '0, "id on full")

endmodule
